// File: design/kpt_pkg.sv
// ----------------------------------------------------------------------------
// kpt_pkg
// Shared constants, codes and types for the keyed priority task table.
// ----------------------------------------------------------------------------
`default_nettype none

package kpt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  localparam int OP_W     = 3;
  localparam int KEY_W    = 16;
  localparam int TIME_W   = 32;
  localparam int PRIO_W   = 16;
  localparam int STATUS_W = 2;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 72;

  // Request opcodes.
  localparam logic [OP_W-1:0] OP_UPSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE  = 3'd3;
  localparam logic [OP_W-1:0] OP_EXISTS  = 3'd4;
  localparam logic [OP_W-1:0] OP_DETAILS = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd6;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]         key;
    logic [TIME_W-1:0]        tm;
    logic signed [PRIO_W-1:0] prio;
  } kpt_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;   // capture the request, restart the sweep
    logic scan;    // issue one entry read and advance the sweep
    logic finish;  // commit the table update and load the result
  } kpt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;  // the read now issued is the last entry
    logic out_free;   // output register can take a result this cycle
  } kpt_stat_t;

endpackage

`default_nettype wire

// File: design/kpt_ctrl.sv
// ----------------------------------------------------------------------------
// kpt_ctrl
// Sequencer: accept a request, sweep the table, commit and hand off result.
// ----------------------------------------------------------------------------
`default_nettype none

module kpt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire kpt_pkg::kpt_stat_t stat,
  output kpt_pkg::kpt_cmd_t      cmd
);
  import kpt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready  = 1'b1;
        cmd.start = s_tvalid;
        if (s_tvalid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read data is evaluated during this cycle
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: design/kpt_datapath.sv
// ----------------------------------------------------------------------------
// kpt_datapath
// Entry memory, valid bits, sweep evaluation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kpt_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [kpt_pkg::IN_DATA_W-1:0]   s_tdata,
  input  wire logic [kpt_pkg::OP_W-1:0]        s_tuser,
  input  wire kpt_pkg::kpt_cmd_t               cmd,
  output kpt_pkg::kpt_stat_t                   stat,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [kpt_pkg::OUT_DATA_W-1:0]       m_tdata
);
  import kpt_pkg::*;

  // Request registers
  logic [OP_W-1:0]          op_q;
  logic [KEY_W-1:0]         id_q;
  logic [TIME_W-1:0]        tm_q;
  logic signed [PRIO_W-1:0] pr_q;

  // Table storage
  kpt_entry_t               mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   valid;

  // Sweep read stage
  logic [IDX_W-1:0]         scan_cnt;
  logic                     rd_vld_q;
  kpt_entry_t               rd_q;
  logic                     rd_used_q;
  logic [IDX_W-1:0]         rd_idx_q;

  // Sweep results
  logic                     found;
  logic [IDX_W-1:0]         found_slot;
  kpt_entry_t               found_ent;
  logic                     free_found;
  logic [IDX_W-1:0]         free_slot;
  logic                     best_found;
  kpt_entry_t               best_ent;
  logic                     rd_better;

  // Commit controls
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic                     set_valid;
  logic                     clr_valid;
  logic                     clr_all;

  // Result fields
  logic [STATUS_W-1:0]      res_status;
  logic                     res_exists;
  logic [KEY_W-1:0]         res_id;
  logic [TIME_W-1:0]        res_time;
  logic signed [PRIO_W-1:0] res_prio;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q <= s_tuser;
      id_q <= s_tdata[15:0];
      tm_q <= s_tdata[47:16];
      pr_q <= s_tdata[63:48];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd.scan;
      if (cmd.start) begin
        scan_cnt <= '0;
      end else if (cmd.scan) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
  end

  assign stat.scan_last = (scan_cnt == IDX_W'(TABLE_DEPTH - 1));
  assign stat.out_free  = !m_tvalid || m_tready;

  // Memory read port
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_q      <= mem[scan_cnt];
      rd_used_q <= valid[scan_cnt];
      rd_idx_q  <= scan_cnt;
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{key: id_q, tm: tm_q, prio: pr_q};
    end
  end

  // Rank: higher priority, then earlier time, then lower key.
  assign rd_better = (rd_q.prio > best_ent.prio) ||
                     ((rd_q.prio == best_ent.prio) &&
                      ((rd_q.tm < best_ent.tm) ||
                       ((rd_q.tm == best_ent.tm) && (rd_q.key < best_ent.key))));

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
    end else if (rd_vld_q) begin
      if (rd_used_q && (rd_q.key == id_q)) begin
        found      <= 1'b1;
        found_slot <= rd_idx_q;
        found_ent  <= rd_q;
      end
      if (!rd_used_q && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= rd_idx_q;
      end
      if (rd_used_q && (!best_found || rd_better)) begin
        best_found <= 1'b1;
        best_ent   <= rd_q;
      end
    end
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = found_slot;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    clr_all    = 1'b0;
    res_status = ST_OK;
    res_exists = 1'b0;
    res_id     = '0;
    res_time   = '0;
    res_prio   = '0;
    case (op_q)
      OP_UPSERT: begin
        res_id = id_q;
        if (found) begin
          wr_en = cmd.finish;
        end else if (free_found) begin
          wr_en     = cmd.finish;
          wr_addr   = free_slot;
          set_valid = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_PEEK: begin
        if (best_found) begin
          res_id   = best_ent.key;
          res_time = best_ent.tm;
          res_prio = best_ent.prio;
        end else begin
          res_status = ST_EMPTY;
        end
      end
      OP_REMOVE: begin
        res_id = id_q;
        if (found) begin
          clr_valid = 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_UPDATE: begin
        res_id = id_q;
        if (found) begin
          wr_en = cmd.finish;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_EXISTS: begin
        res_id     = id_q;
        res_exists = found;
      end
      OP_DETAILS: begin
        res_id = id_q;
        if (found) begin
          res_time = found_ent.tm;
          res_prio = found_ent.prio;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        clr_all = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.finish) begin
      if (clr_all) begin
        valid <= '0;
      end else begin
        if (set_valid) begin
          valid[wr_addr] <= 1'b1;
        end
        if (clr_valid) begin
          valid[found_slot] <= 1'b0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {5'b0, res_prio, res_time, res_id, res_exists, res_status};
    end
  end

endmodule

`default_nettype wire

// File: design/keyed_priority_task_table.sv
// ----------------------------------------------------------------------------
// keyed_priority_task_table
// Keyed task table with best-task lookup, driven by a request stream.
// ----------------------------------------------------------------------------
// Each request on the slave stream names one operation in s_tuser (upsert,
// peek best, remove, update existing, exists, details, clear) and gives one
// result item on the master stream. A request passes from acceptance to the
// next acceptance through an accept state, a sweep of the entry memory at
// one entry per cycle through its single registered read port, a state to
// drain that read stage and a state to commit the table change and load
// the result. The block takes one request at a time; a result waiting in
// the output register does not block acceptance of the next request, but
// that request's commit waits until the register is free. The best task is
// the one with the highest priority, then the earliest time, then the
// lowest id. Reset empties the table at once through per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_priority_task_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [15:0] task_id, [47:16] new_time, [63:48] new_priority
  input  wire logic [kpt_pkg::IN_DATA_W-1:0] s_tdata,
  // [2:0] opcode
  input  wire logic [kpt_pkg::OP_W-1:0]      s_tuser,
  // result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [1:0] status, [2] exists, [18:3] result_id, [50:19] result_time,
  // [66:51] result_priority, [71:67] zero
  output logic [kpt_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import kpt_pkg::*;

  kpt_cmd_t  cmd;
  kpt_stat_t stat;

  // sequence each request: accept, sweep, drain, commit
  kpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hold the table, evaluate the sweep, drive the result register
  kpt_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

// File: design/kpt_checker.sv
// ----------------------------------------------------------------------------
// kpt_checker
// Port-level checks for the keyed priority task table.
// ----------------------------------------------------------------------------
`default_nettype none

module kpt_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [kpt_pkg::OUT_DATA_W-1:0] m_tdata
);
  import kpt_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed or dropped while stalled");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one request at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken during a sweep");

  // an exists answer always carries status ok
  a_exists_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == ST_OK))
    else $error("exists flag with error status");

  // an error result reports no time and no priority
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] != ST_OK)) |-> (m_tdata[66:19] == '0))
    else $error("error result carries task details");

endmodule

bind keyed_priority_task_table kpt_checker u_kpt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// File: dv/keyed_priority_task_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_priority_task_table_test
// Self-checking bench for the keyed task table on its request/result streams.
// ----------------------------------------------------------------------------
// A local model of the table tracks every accepted request and queues the
// result it must produce. Directed items cover the empty, absent-key, tie and
// reserved-opcode cases, a second pass fills the table to overflow, and the
// random pass mixes all opcodes, reserved too, over key pools of varying
// size while both stream sides idle at random.
// ----------------------------------------------------------------------------

module keyed_priority_task_table_test;
  import kpt_pkg::*;

  // Opcode 7 has no operation behind it; the block answers with all zeros.
  localparam logic [OP_W-1:0] OP_RESERVED = 3'd7;
  localparam int MAX_REPORTS = 10;

  // Packed from the top bit down, so status lands in the lowest bits.
  typedef struct packed {
    logic signed [PRIO_W-1:0] rprio;
    logic [TIME_W-1:0]        rtime;
    logic [KEY_W-1:0]         rid;
    logic                     exists;
    logic [STATUS_W-1:0]      status;
  } task_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Local copy of the task table.
  logic                     slot_used [TABLE_DEPTH];
  logic [KEY_W-1:0]         slot_key  [TABLE_DEPTH];
  logic [TIME_W-1:0]        slot_time [TABLE_DEPTH];
  logic signed [PRIO_W-1:0] slot_prio [TABLE_DEPTH];

  task_result_t pending_results[$];
  task_result_t seen_result;
  task_result_t due_result;
  int           mismatch_count = 0;
  bit           idle_enable = 1'b1;
  int           ready_stall = 0;

  keyed_priority_task_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [15:0] task_id, [47:16] new_time, [63:48] new_priority
    .s_tuser  (s_tuser),   // [2:0] opcode
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [1:0] status, [2] exists, [18:3] id, [50:19] time,
                           // [66:51] priority, [71:67] zero
  );

  always #2 clk = ~clk;

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("keyed_priority_task_table_test: FAIL");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none while idling is off.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  function automatic int find_key(input logic [KEY_W-1:0] key);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (slot_used[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  // Apply one request to the local table and return the result it gives.
  function automatic task_result_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic [KEY_W-1:0] id,
                                                 input logic [TIME_W-1:0] tm,
                                                 input logic signed [PRIO_W-1:0] pr);
    task_result_t res;
    int slot;
    res = '0;
    slot = -1;
    case (op)
      OP_UPSERT: begin
        res.rid = id;
        slot = find_key(id);
        // A new key takes the lowest free slot.
        if (slot < 0)
          for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            if (!slot_used[i]) slot = i;
        if (slot < 0) begin
          res.status = ST_FULL;
        end else begin
          slot_used[slot] = 1'b1;
          slot_key[slot]  = id;
          slot_time[slot] = tm;
          slot_prio[slot] = pr;
        end
      end
      OP_PEEK: begin
        // Highest priority, then earliest time, then lowest key.
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (slot_used[i] && (slot < 0 ||
              slot_prio[i] > slot_prio[slot] ||
              (slot_prio[i] == slot_prio[slot] && (slot_time[i] < slot_time[slot] ||
               (slot_time[i] == slot_time[slot] && slot_key[i] < slot_key[slot])))))
            slot = i;
        if (slot < 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.rid   = slot_key[slot];
          res.rtime = slot_time[slot];
          res.rprio = slot_prio[slot];
        end
      end
      OP_REMOVE: begin
        res.rid = id;
        slot = find_key(id);
        if (slot < 0) res.status = ST_NOT_FOUND;
        else slot_used[slot] = 1'b0;
      end
      OP_UPDATE: begin
        res.rid = id;
        slot = find_key(id);
        if (slot < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          slot_time[slot] = tm;
          slot_prio[slot] = pr;
        end
      end
      OP_EXISTS: begin
        res.rid = id;
        res.exists = (find_key(id) >= 0);
      end
      OP_DETAILS: begin
        res.rid = id;
        slot = find_key(id);
        if (slot < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.rtime = slot_time[slot];
          res.rprio = slot_prio[slot];
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch in %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
  endtask

  // Drive one request at the falling edge, hold it until accepted, then queue
  // its expected result. Valid stays high when no gap follows.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] id,
                              input logic [TIME_W-1:0] tm,
                              input logic signed [PRIO_W-1:0] pr);
    int gap;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {pr, tm, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_request(op, id, tm, pr));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      s_tdata  = {$urandom, $urandom};
      s_tuser  = OP_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and hold off until every queued result has come back.
  task automatic wait_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall at random, sampled at the rising edge by the checker.
  always @(negedge clk) begin
    if (ready_stall > 0) begin
      m_tready = 1'b0;
      ready_stall--;
    end else begin
      m_tready = 1'b1;
      if ($urandom_range(0, 7) == 0) ready_stall = pick_gap();
    end
  end

  // Result checker: compare each accepted item with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_result = m_tdata[66:0];
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, m_tdata[63:0]);
      end else begin
        due_result = pending_results.pop_front();
        if (seen_result.status !== due_result.status)
          note_mismatch("status", 64'(due_result.status), 64'(seen_result.status));
        if (seen_result.exists !== due_result.exists)
          note_mismatch("exists", 64'(due_result.exists), 64'(seen_result.exists));
        if (seen_result.rid !== due_result.rid)
          note_mismatch("result_id", 64'(due_result.rid), 64'(seen_result.rid));
        if (seen_result.rtime !== due_result.rtime)
          note_mismatch("result_time", 64'(due_result.rtime), 64'(seen_result.rtime));
        if (seen_result.rprio !== due_result.rprio)
          note_mismatch("result_priority", 64'(due_result.rprio),
                        64'(seen_result.rprio));
      end
    end
  end

  // Empty-table answers, absent keys, overwrite, the three tie-break levels,
  // reserved opcode, clear, and field extremes.
  task automatic directed_test();
    send_request(OP_PEEK,    16'h0000, 32'h0, 16'sh0);
    send_request(OP_REMOVE,  16'h1234, 32'h0, 16'sh0);
    send_request(OP_UPDATE,  16'h1234, 32'h1, 16'sh1);
    send_request(OP_DETAILS, 16'h1234, 32'h0, 16'sh0);
    send_request(OP_EXISTS,  16'h1234, 32'h0, 16'sh0);
    send_request(OP_UPSERT,  16'h0000, 32'h0, 16'sh8000);
    send_request(OP_UPSERT,  16'hFFFF, 32'hFFFF_FFFF, 16'sh7FFF);
    send_request(OP_PEEK,    16'h0000, 32'h0, 16'sh0);
    // Overwrite a present key; priorities now tie, time decides.
    send_request(OP_UPSERT,  16'hFFFF, 32'h5, 16'sh8000);
    send_request(OP_PEEK,    16'h0000, 32'h0, 16'sh0);
    // Full tie with key 0: the lower key wins.
    send_request(OP_UPSERT,  16'h00AA, 32'h0, 16'sh8000);
    send_request(OP_PEEK,    16'h0000, 32'h0, 16'sh0);
    send_request(OP_REMOVE,  16'h0000, 32'h0, 16'sh0);
    send_request(OP_PEEK,    16'h0000, 32'h0, 16'sh0);
    send_request(OP_UPDATE,  16'h00AA, 32'hFFFF_FFFF, 16'sh7FFF);
    send_request(OP_DETAILS, 16'h00AA, 32'h0, 16'sh0);
    send_request(OP_EXISTS,  16'h00AA, 32'h0, 16'sh0);
    send_request(OP_DETAILS, 16'hFFFF, 32'h0, 16'sh0);
    send_request(OP_RESERVED, 16'hFFFF, 32'hFFFF_FFFF, 16'shFFFF);
    send_request(OP_CLEAR,   16'h0000, 32'h0, 16'sh0);
    send_request(OP_PEEK,    16'h0000, 32'h0, 16'sh0);
    send_request(OP_EXISTS,  16'hFFFF, 32'h0, 16'sh0);
    send_request(OP_UPSERT,  16'h5555, 32'hAAAA_AAAA, 16'sh5555);
    send_request(OP_UPSERT,  16'hAAAA, 32'h5555_5555, 16'shAAAA);
    send_request(OP_PEEK,    16'h0000, 32'h0, 16'sh0);
  endtask

  // Fill every slot, overflow it, free one slot and refill it.
  task automatic full_table_test();
    logic [KEY_W-1:0] base;
    base = KEY_W'($urandom);
    send_request(OP_CLEAR, 16'h0, 32'h0, 16'sh0);
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_request(OP_UPSERT, KEY_W'(base + i), $urandom_range(0, 7),
                   PRIO_W'($urandom_range(0, 3) - 1));
    // Let the whole fill settle before probing the full table.
    wait_drain();
    send_request(OP_UPSERT,  KEY_W'(base + TABLE_DEPTH), 32'h0, 16'sh7FFF);
    send_request(OP_UPSERT,  KEY_W'(base + 3), 32'h0, 16'sh7FFF);
    send_request(OP_PEEK,    16'h0, 32'h0, 16'sh0);
    send_request(OP_REMOVE,  KEY_W'(base + 10), 32'h0, 16'sh0);
    send_request(OP_UPSERT,  KEY_W'(base + TABLE_DEPTH), 32'h0, 16'sh7FFF);
    send_request(OP_UPSERT,  KEY_W'(base + TABLE_DEPTH + 1), 32'h0, 16'sh0);
    send_request(OP_PEEK,    16'h0, 32'h0, 16'sh0);
    send_request(OP_DETAILS, KEY_W'(base + TABLE_DEPTH), 32'h0, 16'sh0);
    send_request(OP_CLEAR,   16'h0, 32'h0, 16'sh0);
  endtask

  // Random operations in batches, each over its own key pool. Small pools
  // give many hits; the large pool drives the table to full.
  task automatic random_test(input int item_goal);
    logic [KEY_W-1:0]         key_pool [0:95];
    logic [OP_W-1:0]          op;
    logic [KEY_W-1:0]         id;
    logic [TIME_W-1:0]        tm;
    logic signed [PRIO_W-1:0] pr;
    int pool_size;
    int done;
    int batch;
    int r;
    done  = 0;
    batch = 0;
    while (done < item_goal) begin
      case (batch % 4)
        0:       pool_size = 6;
        1:       pool_size = 24;
        2:       pool_size = 90;
        default: pool_size = 12;
      endcase
      for (int i = 0; i < 96; i++) key_pool[i] = KEY_W'($urandom);
      // Every fifth batch runs with no idling on either side.
      idle_enable = (batch % 5 != 4);
      repeat (60) begin
        r = $urandom_range(0, 99);
        if (pool_size > TABLE_DEPTH) r = (r < 60) ? 0 : r;
        if (r < 40)      op = OP_UPSERT;
        else if (r < 55) op = OP_PEEK;
        else if (r < 67) op = OP_REMOVE;
        else if (r < 77) op = OP_UPDATE;
        else if (r < 84) op = OP_EXISTS;
        else if (r < 95) op = OP_DETAILS;
        else if (r < 97) op = (pool_size > TABLE_DEPTH) ? OP_DETAILS : OP_CLEAR;
        else             op = OP_RESERVED;
        id = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                          : key_pool[$urandom_range(0, pool_size - 1)];
        case ($urandom_range(0, 3))
          0:       tm = $urandom_range(0, 3);
          1:       tm = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          default: tm = $urandom;
        endcase
        pr = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2) - 1);
        send_request(op, id, tm, pr);
        if (op != OP_RESERVED) done++;
      end
      batch++;
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_test();
    wait_drain();
    full_table_test();
    wait_drain();
    random_test(400);
    wait_drain();

    // Catch any stray result after the last expected one.
    repeat (150) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("keyed_priority_task_table_test: PASS");
    end else begin
      $display("keyed_priority_task_table_test: FAIL");
    end
    $finish;
  end

endmodule
